>>> rtl/gpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

    localparam int PinW = 8;

    typedef logic [PinW-1:0] pin_vec_t;

    typedef enum logic [1:0] {
        FuncRead   = 2'd0,
        FuncWrite  = 2'd1,
        FuncSample = 2'd2
    } func_t;

    localparam logic [31:0] LockKey = 32'h4C4F_434B;

    localparam logic [11:0] OfsDir   = 12'h400;
    localparam logic [11:0] OfsIs    = 12'h404;
    localparam logic [11:0] OfsIbe   = 12'h408;
    localparam logic [11:0] OfsIev   = 12'h40C;
    localparam logic [11:0] OfsIm    = 12'h410;
    localparam logic [11:0] OfsRis   = 12'h414;
    localparam logic [11:0] OfsMis   = 12'h418;
    localparam logic [11:0] OfsIcr   = 12'h41C;
    localparam logic [11:0] OfsAfsel = 12'h420;
    localparam logic [11:0] OfsOdr   = 12'h50C;
    localparam logic [11:0] OfsPur   = 12'h510;
    localparam logic [11:0] OfsPdr   = 12'h514;
    localparam logic [11:0] OfsDen   = 12'h51C;
    localparam logic [11:0] OfsLock  = 12'h520;
    localparam logic [11:0] OfsCr    = 12'h524;

    typedef struct packed {
        pin_vec_t sense_level;
        pin_vec_t both_edges;
        pin_vec_t event_polarity;
        pin_vec_t den_mask;
        pin_vec_t previous_pins;
    } detect_cfg_t;

    typedef struct packed {
        pin_vec_t sampled;
        pin_vec_t events;
    } detect_res_t;

endpackage

`default_nettype wire

>>> rtl/gpio_port_with_edge_interrupts.sv
`timescale 1ns / 1ps
`default_nettype none

// Eight-pin GPIO port with level and edge interrupts behind a register map.
// Input stream: each transfer is a bus read, a bus write or a pin sample tick,
// selected by s_axis_tuser; offset, write data and pad levels ride in tdata.
// Output stream: one transfer per input transfer, carrying the read data,
// the interrupt line and all pad controls as they stand after that item.
// The state registers and the result register update at the same edge that
// accepts the item. Unstalled, throughput is one item per cycle;
// the only storage on the path is the result register, so s_axis_tready is
// high whenever that register is empty or is being taken this cycle.
// When the receiver stalls, the result holds and the input stalls with it.
// cfg_wen/cfg_wdata set the protected pin mask; write it only while idle.
// Unprotected pins get their commit bit forced to 1 on that write.
// Reset (aresetn low, synchronous) clears every state register but the commit
// bits, which it sets, locks the port and empties the result register.

module gpio_port_with_edge_interrupts #(
    parameter int PIN_COUNT = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wen,
    input  wire  [7:0]  cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] reg_offset, [43:12] write_data, [51:44] pin_levels, [55:52] zero
    input  wire  [55:0] s_axis_tdata,
    // [1:0] func
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] read_data, [8] irq, [16:9] pad_out, [24:17] pad_oe,
    // [32:25] pad_od, [40:33] pad_pull_up, [48:41] pad_pull_dn,
    // [56:49] pad_alt, [64:57] pad_digital, [71:65] zero
    output logic [71:0] m_axis_tdata
);
    import gpe_pkg::*;

    localparam pin_vec_t RegMask = (PIN_COUNT >= PinW) ? {PinW{1'b1}} :
                                   PinW'((64'd1 << PIN_COUNT) - 64'd1);

    pin_vec_t out_latch_reg, out_latch_next;
    pin_vec_t direction_reg, direction_next;
    pin_vec_t sense_reg, sense_next;
    pin_vec_t both_reg, both_next;
    pin_vec_t polarity_reg, polarity_next;
    pin_vec_t mask_reg, mask_next;
    pin_vec_t raw_reg, raw_next;
    pin_vec_t alt_reg, alt_next;
    pin_vec_t od_reg, od_next;
    pin_vec_t pu_reg, pu_next;
    pin_vec_t pd_reg, pd_next;
    pin_vec_t den_reg, den_next;
    pin_vec_t commit_reg, commit_next;
    pin_vec_t prev_reg, prev_next;
    pin_vec_t protected_reg;
    logic     unlocked_reg, unlocked_next;

    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    logic        in_fire;
    func_t       func;
    logic [11:0] ofs;
    logic [31:0] wd;
    pin_vec_t    v;
    pin_vec_t    sel;
    pin_vec_t    pins;
    pin_vec_t    rd;
    logic        irq_next;

    detect_cfg_t det_cfg;
    detect_res_t det_res;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign func          = func_t'(s_axis_tuser);
    assign ofs           = {s_axis_tdata[11:2], 2'b00};
    assign wd            = s_axis_tdata[43:12];
    assign pins          = s_axis_tdata[51:44] & RegMask;
    assign v             = wd[PinW-1:0] & RegMask;
    assign sel           = ofs[9:2] & RegMask;

    assign det_cfg = '{sense_level:    sense_reg,
                       both_edges:     both_reg,
                       event_polarity: polarity_reg,
                       den_mask:       den_reg,
                       previous_pins:  prev_reg};

    gpe_detect u_detect (
        .pin_levels (pins),
        .cfg        (det_cfg),
        .res        (det_res)
    );

    always_comb begin
        out_latch_next = out_latch_reg;
        direction_next = direction_reg;
        sense_next     = sense_reg;
        both_next      = both_reg;
        polarity_next  = polarity_reg;
        mask_next      = mask_reg;
        raw_next       = raw_reg;
        alt_next       = alt_reg;
        od_next        = od_reg;
        pu_next        = pu_reg;
        pd_next        = pd_reg;
        den_next       = den_reg;
        commit_next    = commit_reg;
        prev_next      = prev_reg;
        unlocked_next  = unlocked_reg;
        rd             = '0;
        if (in_fire) begin
            case (func)
                FuncRead: begin
                    if (ofs[11:10] == 2'b00) begin
                        rd = ((out_latch_reg & direction_reg) |
                              (prev_reg & ~direction_reg)) & sel;
                    end else begin
                        case (ofs)
                            OfsDir:   rd = direction_reg;
                            OfsIs:    rd = sense_reg;
                            OfsIbe:   rd = both_reg;
                            OfsIev:   rd = polarity_reg;
                            OfsIm:    rd = mask_reg;
                            OfsRis:   rd = raw_reg;
                            OfsMis:   rd = raw_reg & mask_reg;
                            OfsAfsel: rd = alt_reg;
                            OfsOdr:   rd = od_reg;
                            OfsPur:   rd = pu_reg;
                            OfsPdr:   rd = pd_reg;
                            OfsDen:   rd = den_reg;
                            OfsLock:  rd = {{(PinW-1){1'b0}}, !unlocked_reg};
                            OfsCr:    rd = commit_reg;
                            default:  rd = '0;
                        endcase
                    end
                end
                FuncWrite: begin
                    if (ofs[11:10] == 2'b00) begin
                        out_latch_next = (out_latch_reg & ~sel) | (v & sel);
                    end else begin
                        case (ofs)
                            OfsDir: direction_next = v;
                            OfsIs:  sense_next     = v;
                            OfsIbe: both_next      = v;
                            OfsIev: polarity_next  = v;
                            OfsIm:  mask_next      = v;
                            OfsIcr: raw_next       = raw_reg & ~v;
                            OfsAfsel: begin
                                alt_next = (alt_reg & ~commit_reg) | (v & commit_reg);
                            end
                            OfsOdr: od_next = v;
                            OfsPur: begin
                                pu_next = (pu_reg & ~commit_reg) | (v & commit_reg);
                                pd_next = pd_reg & ~(v & commit_reg);
                            end
                            OfsPdr: begin
                                pd_next = (pd_reg & ~commit_reg) | (v & commit_reg);
                                pu_next = pu_reg & ~(v & commit_reg);
                            end
                            OfsDen: begin
                                den_next = (den_reg & ~commit_reg) | (v & commit_reg);
                            end
                            OfsLock: unlocked_next = (wd == LockKey);
                            OfsCr: begin
                                if (unlocked_reg) begin
                                    commit_next = (~protected_reg | (v & protected_reg)) &
                                                  RegMask;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                FuncSample: begin
                    raw_next  = (raw_reg | det_res.events) & RegMask;
                    prev_next = det_res.sampled;
                end
                default: ;
            endcase
        end
        irq_next = |(raw_next & mask_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_latch_reg <= '0;
            direction_reg <= '0;
            sense_reg     <= '0;
            both_reg      <= '0;
            polarity_reg  <= '0;
            mask_reg      <= '0;
            raw_reg       <= '0;
            alt_reg       <= '0;
            od_reg        <= '0;
            pu_reg        <= '0;
            pd_reg        <= '0;
            den_reg       <= '0;
            commit_reg    <= RegMask;
            prev_reg      <= '0;
            protected_reg <= '0;
            unlocked_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_latch_reg <= out_latch_next;
            direction_reg <= direction_next;
            sense_reg     <= sense_next;
            both_reg      <= both_next;
            polarity_reg  <= polarity_next;
            mask_reg      <= mask_next;
            raw_reg       <= raw_next;
            alt_reg       <= alt_next;
            od_reg        <= od_next;
            pu_reg        <= pu_next;
            pd_reg        <= pd_next;
            den_reg       <= den_next;
            prev_reg      <= prev_next;
            unlocked_reg  <= unlocked_next;
            if (cfg_wen) begin
                protected_reg <= cfg_wdata & RegMask;
                commit_reg    <= (commit_next | ~cfg_wdata) & RegMask;
            end else begin
                commit_reg    <= commit_next;
            end
            if (in_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_data_reg <= {7'd0, den_next, alt_next, pd_next, pu_next, od_next,
                             direction_next, out_latch_next, irq_next, rd};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_commit_unprotected: assert property (@(posedge aclk) disable iff (!aresetn)
        ((commit_reg | protected_reg) & RegMask) == RegMask)
        else $error("commit bit of an unprotected pin is clear");

    a_pull_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (pu_reg & pd_reg) == '0)
        else $error("pull-up and pull-down both enabled on a pin");

    a_raw_clear_by_icr: assert property (@(posedge aclk) disable iff (!aresetn)
        (|($past(raw_reg) & ~raw_reg)) |->
            $past(in_fire && func == FuncWrite && ofs == OfsIcr))
        else $error("raw status bit dropped without an ICR write");

    a_unlock_by_key: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(unlocked_reg) |->
            $past(in_fire && func == FuncWrite && ofs == OfsLock && wd == LockKey))
        else $error("port unlocked without the key");

endmodule

`default_nettype wire

>>> rtl/gpe_detect.sv
`timescale 1ns / 1ps
`default_nettype none

module gpe_detect (
    input  wire gpe_pkg::pin_vec_t    pin_levels,
    input  wire gpe_pkg::detect_cfg_t cfg,
    output gpe_pkg::detect_res_t      res
);
    import gpe_pkg::*;

    pin_vec_t p;
    pin_vec_t rise;
    pin_vec_t fall;
    pin_vec_t edge_hit;
    pin_vec_t level_hit;

    always_comb begin
        p         = pin_levels & cfg.den_mask;
        rise      = p & ~cfg.previous_pins;
        fall      = ~p & cfg.previous_pins;
        edge_hit  = (cfg.both_edges & (rise | fall)) |
                    (~cfg.both_edges & ((cfg.event_polarity & rise) |
                                        (~cfg.event_polarity & fall)));
        level_hit = (cfg.event_polarity & p) | (~cfg.event_polarity & ~p);
        res.sampled = p;
        res.events  = (cfg.sense_level & level_hit) | (~cfg.sense_level & edge_hit);
    end

endmodule

`default_nettype wire

>>> tb/gpio_port_with_edge_interrupts_tb.sv
`timescale 1ns / 1ps

module gpio_port_with_edge_interrupts_tb;

    import gpe_pkg::*;

    localparam logic [1:0]  FuncUnused   = 2'd3;
    localparam logic [11:0] OfsDataTop   = 12'h3FC;
    localparam logic [11:0] OfsWordMask  = 12'hFFC;
    localparam int          RunLimit     = 1_000_000;
    localparam int          HoldCycles   = 300;
    localparam int          SettleCycles = 4;
    localparam int          PrintCap     = 40;

    typedef struct packed {
        pin_vec_t out_latch;
        pin_vec_t direction;
        pin_vec_t sense_level;
        pin_vec_t both_edges;
        pin_vec_t event_pol;
        pin_vec_t irq_mask;
        pin_vec_t raw_status;
        pin_vec_t alt_select;
        pin_vec_t od_mode;
        pin_vec_t pull_up;
        pin_vec_t pull_dn;
        pin_vec_t digital_en;
        pin_vec_t commit;
        pin_vec_t prev_pins;
        pin_vec_t guarded;
        logic     unlocked;
    } port_state_t;

    typedef struct packed {
        logic [6:0] zero_pad;
        pin_vec_t   pad_digital;
        pin_vec_t   pad_alt;
        pin_vec_t   pad_pull_dn;
        pin_vec_t   pad_pull_up;
        pin_vec_t   pad_od;
        pin_vec_t   pad_oe;
        pin_vec_t   pad_out;
        logic       irq;
        logic [7:0] read_data;
    } port_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wen       = 1'b0;
    logic [7:0]  cfg_wdata     = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = 2'd0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [71:0] m_axis_tdata;

    port_state_t  port;
    port_result_t expected_results[$];

    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int guard_settings  = 0;
    bit sender_idle_on   = 1'b0;
    bit receiver_idle_on = 1'b0;
    bit hold_req         = 1'b0;

    gpio_port_with_edge_interrupts u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic pin_vec_t gated(pin_vec_t old, pin_vec_t val);
        return (old & ~port.commit) | (val & port.commit);
    endfunction

    task automatic port_apply(input logic [1:0] f, input logic [11:0] raw_ofs,
                              input logic [31:0] wd, input pin_vec_t pins,
                              output port_result_t r);
        logic [11:0] ofs;
        pin_vec_t    v, sel, p, rise, fall, edge_ev, level_ev;
        ofs = raw_ofs & OfsWordMask;
        v   = wd[7:0];
        sel = ofs[9:2];
        r   = '0;
        if (f == FuncRead) begin
            if (ofs <= OfsDataTop) begin
                r.read_data = ((port.out_latch & port.direction) |
                               (port.prev_pins & ~port.direction)) & sel;
            end else begin
                case (ofs)
                    OfsDir:   r.read_data = port.direction;
                    OfsIs:    r.read_data = port.sense_level;
                    OfsIbe:   r.read_data = port.both_edges;
                    OfsIev:   r.read_data = port.event_pol;
                    OfsIm:    r.read_data = port.irq_mask;
                    OfsRis:   r.read_data = port.raw_status;
                    OfsMis:   r.read_data = port.raw_status & port.irq_mask;
                    OfsAfsel: r.read_data = port.alt_select;
                    OfsOdr:   r.read_data = port.od_mode;
                    OfsPur:   r.read_data = port.pull_up;
                    OfsPdr:   r.read_data = port.pull_dn;
                    OfsDen:   r.read_data = port.digital_en;
                    OfsLock:  r.read_data = port.unlocked ? 8'h00 : 8'h01;
                    OfsCr:    r.read_data = port.commit;
                    default:  r.read_data = 8'h00;
                endcase
            end
        end else if (f == FuncWrite) begin
            if (ofs <= OfsDataTop) begin
                port.out_latch = (port.out_latch & ~sel) | (v & sel);
            end else begin
                case (ofs)
                    OfsDir:   port.direction   = v;
                    OfsIs:    port.sense_level = v;
                    OfsIbe:   port.both_edges  = v;
                    OfsIev:   port.event_pol   = v;
                    OfsIm:    port.irq_mask    = v;
                    OfsIcr:   port.raw_status  = port.raw_status & ~v;
                    OfsAfsel: port.alt_select  = gated(port.alt_select, v);
                    OfsOdr:   port.od_mode     = v;
                    OfsPur: begin
                        port.pull_up = gated(port.pull_up, v);
                        port.pull_dn = port.pull_dn & ~(v & port.commit);
                    end
                    OfsPdr: begin
                        port.pull_dn = gated(port.pull_dn, v);
                        port.pull_up = port.pull_up & ~(v & port.commit);
                    end
                    OfsDen:   port.digital_en = gated(port.digital_en, v);
                    OfsLock:  port.unlocked   = (wd == LockKey);
                    OfsCr: begin
                        if (port.unlocked) port.commit = ~port.guarded | (v & port.guarded);
                    end
                    default: ;
                endcase
            end
        end else if (f == FuncSample) begin
            p        = pins & port.digital_en;
            rise     = p & ~port.prev_pins;
            fall     = ~p & port.prev_pins;
            edge_ev  = (port.both_edges & (rise | fall)) |
                       (~port.both_edges & ((port.event_pol & rise) |
                                            (~port.event_pol & fall)));
            level_ev = (port.event_pol & p) | (~port.event_pol & ~p);
            port.raw_status = port.raw_status | (port.sense_level & level_ev) |
                              (~port.sense_level & edge_ev);
            port.prev_pins  = p;
        end
        r.irq         = |(port.raw_status & port.irq_mask);
        r.pad_out     = port.out_latch;
        r.pad_oe      = port.direction;
        r.pad_od      = port.od_mode;
        r.pad_pull_up = port.pull_up;
        r.pad_pull_dn = port.pull_dn;
        r.pad_alt     = port.alt_select;
        r.pad_digital = port.digital_en;
    endtask

    task automatic bus_transfer(input logic [1:0] f, input logic [11:0] ofs,
                                input logic [31:0] wd, input pin_vec_t pins);
        port_result_t r;
        int           gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {4'b0, pins, wd, ofs};
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        port_apply(f, ofs, wd, pins, r);
        expected_results.push_back(r);
        items_sent++;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic reg_read(input logic [11:0] ofs);
        bus_transfer(FuncRead, ofs, $urandom, pin_vec_t'($urandom));
    endtask

    task automatic reg_write(input logic [11:0] ofs, input logic [31:0] wd);
        bus_transfer(FuncWrite, ofs, wd, pin_vec_t'($urandom));
    endtask

    task automatic pin_tick(input pin_vec_t pins);
        bus_transfer(FuncSample, 12'($urandom), $urandom, pins);
    endtask

    task automatic drain_port();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic set_guarded_pins(input pin_vec_t v);
        drain_port();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen      <= 1'b0;
        port.guarded = v;
        port.commit  = port.commit | ~v;
        guard_settings++;
    endtask

    function automatic logic [11:0] data_ofs();
        logic [7:0] m;
        logic [1:0] lo;
        m  = 8'($urandom);
        lo = 2'($urandom);
        return {2'b00, m, lo};
    endfunction

    function automatic logic [11:0] pick_gated();
        case ($urandom_range(0, 3))
            0:       return OfsAfsel;
            1:       return OfsPur;
            2:       return OfsPdr;
            default: return OfsDen;
        endcase
    endfunction

    function automatic logic [11:0] pick_mapped();
        logic [11:0] ofs;
        logic [1:0]  lo;
        lo = 2'($urandom);
        case ($urandom_range(0, 15))
            0:       ofs = data_ofs();
            1:       ofs = OfsDir;
            2:       ofs = OfsIs;
            3:       ofs = OfsIbe;
            4:       ofs = OfsIev;
            5:       ofs = OfsIm;
            6:       ofs = OfsRis;
            7:       ofs = OfsMis;
            8:       ofs = OfsIcr;
            9:       ofs = OfsAfsel;
            10:      ofs = OfsOdr;
            11:      ofs = OfsPur;
            12:      ofs = OfsPdr;
            13:      ofs = OfsDen;
            14:      ofs = OfsLock;
            default: ofs = OfsCr;
        endcase
        return ofs | {10'd0, lo};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PrintCap)
            $display("MISMATCH at result %0d: %s got %h want %h",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        port_result_t got, want;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got = m_axis_tdata;
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", got.read_data, 8'h00);
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", got.read_data, want.read_data);
                check_field("irq", {7'd0, got.irq}, {7'd0, want.irq});
                check_field("pad_out", got.pad_out, want.pad_out);
                check_field("pad_oe", got.pad_oe, want.pad_oe);
                check_field("pad_od", got.pad_od, want.pad_od);
                check_field("pad_pull_up", got.pad_pull_up, want.pad_pull_up);
                check_field("pad_pull_dn", got.pad_pull_dn, want.pad_pull_dn);
                check_field("pad_alt", got.pad_alt, want.pad_alt);
                check_field("pad_digital", got.pad_digital, want.pad_digital);
                check_field("zero pad", {1'b0, got.zero_pad}, {1'b0, want.zero_pad});
            end
        end
    end

    initial begin : receiver_pace
        int hold_cnt;
        int gap_cnt;
        hold_cnt = 0;
        gap_cnt  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HoldCycles;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (gap_cnt > 0) begin
                gap_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (receiver_idle_on && $urandom_range(0, 3) == 0) gap_cnt = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RunLimit) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, expected_results.size());
        $display("gpio_port_with_edge_interrupts_tb failed");
        $finish;
    end

    task automatic test_register_map();
        reg_read(OfsLock);
        reg_read(OfsCr);
        reg_write(OfsDir, 32'hFFFF_FFFF);
        reg_write(OfsDataTop, 32'hFFFF_FFFF);
        reg_read(12'h2AB);
        reg_write(12'h000, 32'h0000_0000);
        reg_read(OfsDataTop);
        reg_write(OfsRis, 32'hFFFF_FFFF);
        reg_read(12'hFFF);
        bus_transfer(FuncUnused, 12'hFFF, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_interrupt_detect();
        reg_write(OfsDir, 32'h0000_0000);
        reg_write(OfsDen, 32'h0000_00FF);
        reg_write(OfsIs, 32'h0000_0003);
        reg_write(OfsIbe, 32'h0000_000C);
        reg_write(OfsIev, 32'h0000_0055);
        reg_write(OfsIm, 32'h0000_00FF);
        pin_tick(8'hFF);
        pin_tick(8'h00);
        reg_read(OfsRis);
        reg_write(OfsIcr, 32'h0000_00FF);
        reg_read(OfsMis);
    endtask

    task automatic test_lock_commit();
        reg_write(OfsCr, 32'h0000_0000);
        reg_write(OfsLock, LockKey);
        reg_read(OfsLock);
        reg_write(OfsCr, 32'h0000_0000);
        reg_write(OfsPur, 32'h0000_00FF);
        reg_write(OfsPdr, 32'h0000_00FF);
        reg_write(OfsAfsel, 32'h0000_00FF);
        reg_write(OfsLock, LockKey ^ 32'h1);
        reg_read(OfsCr);
    endtask

    task automatic test_random_traffic(input int n);
        int          start;
        logic [1:0]  f;
        logic [11:0] ofs;
        start = items_sent;
        while (items_sent - start < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    if ($urandom_range(0, 1) == 0) begin
                        reg_write(OfsLock, LockKey);
                        reg_write(OfsCr, 32'hFFFF_FFFF);
                    end
                    reg_write(OfsDen, ($urandom_range(0, 1) == 0) ? 32'hFF : $urandom);
                    reg_write(OfsIs, $urandom);
                    reg_write(OfsIbe, $urandom);
                    reg_write(OfsIev, $urandom);
                    reg_write(OfsIm, $urandom);
                    repeat ($urandom_range(2, 8)) pin_tick(pin_vec_t'($urandom));
                    reg_read(OfsRis);
                    reg_read(OfsMis);
                    reg_write(OfsIcr, $urandom);
                    reg_read(OfsRis);
                end
                3, 4: begin
                    reg_write(OfsLock, LockKey);
                    reg_write(OfsCr, $urandom);
                    reg_read(OfsCr);
                    repeat (2) reg_write(pick_gated(), $urandom);
                    reg_read(pick_gated());
                    reg_write(OfsLock, ($urandom_range(0, 3) == 0) ? LockKey : $urandom);
                    reg_read(OfsLock);
                end
                5, 6: begin
                    reg_write(OfsDir, $urandom);
                    reg_write(data_ofs(), $urandom);
                    pin_tick(pin_vec_t'($urandom));
                    reg_read(data_ofs());
                end
                7: begin
                    repeat (3) begin
                        f   = 2'($urandom_range(0, 3));
                        ofs = 12'($urandom);
                        bus_transfer(f, ofs, $urandom, pin_vec_t'($urandom));
                    end
                end
                8: begin
                    repeat (4) begin
                        f = ($urandom_range(0, 1) == 0) ? FuncRead : FuncWrite;
                        bus_transfer(f, pick_mapped(), $urandom, pin_vec_t'($urandom));
                    end
                end
                default: begin
                    reg_write(OfsLock, LockKey ^ (32'h1 << $urandom_range(0, 31)));
                    reg_write(OfsCr, $urandom);
                    reg_read(OfsCr);
                    reg_read(OfsLock);
                end
            endcase
        end
    endtask

    task automatic test_receiver_backpressure();
        logic [1:0] f;
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        hold_req         = 1'b1;
        repeat (60) begin
            f = 2'($urandom_range(0, 2));
            bus_transfer(f, pick_mapped(), $urandom, pin_vec_t'($urandom));
        end
    endtask

    initial begin
        port        = '0;
        port.commit = 8'hFF;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_guarded_pins(8'hF0);
        test_register_map();
        test_interrupt_detect();
        test_lock_commit();

        set_guarded_pins(8'hFF);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        test_random_traffic(500);
        test_receiver_backpressure();

        set_guarded_pins(8'h00);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        test_random_traffic(150);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        test_random_traffic(350);

        set_guarded_pins(pin_vec_t'($urandom));
        test_random_traffic(500);
        drain_port();

        $display("covered %0d transfers in and %0d results checked over %0d protected-pin masks",
                 items_sent, results_checked, guard_settings);
        $display("reads, writes, pin ticks, lock and commit, one long receiver hold; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("gpio_port_with_edge_interrupts_tb passed");
        end else begin
            $display("gpio_port_with_edge_interrupts_tb failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/gpe_pkg.sv
rtl/gpe_detect.sv
rtl/gpio_port_with_edge_interrupts.sv
tb/gpio_port_with_edge_interrupts_tb.sv
